/* design/ntp_offset_server_select_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the NTP offset server select block.
// Both macros sample on clk and are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef NTP_OFFSET_SERVER_SELECT_ASSERT_SVH
`define NTP_OFFSET_SERVER_SELECT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NOSS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NOSS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/noss_pkg.sv */
// ----------------------------------------------------------------------------
// noss_pkg
// Shared constants, word types and controller/datapath signal groups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package noss_pkg;

	// Store geometry.
	localparam int MAX_SERVERS = 16;
	localparam int SAMPLES     = 4;
	localparam int SRV_W       = $clog2(MAX_SERVERS);
	localparam int SMP_W       = $clog2(SAMPLES);
	localparam int CNT_W       = $clog2(SAMPLES + 1);
	localparam int ADDR_W      = SRV_W + SMP_W;
	localparam int MEM_DEPTH   = MAX_SERVERS * SAMPLES;

	// Server count register.
	localparam int CFG_W = 5;
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

	// Arithmetic widths: 64-bit timestamps, 67-bit exact sums.
	localparam int TS_W        = 64;
	localparam int WIDE_W      = TS_W + 3;
	localparam int MAG_W       = WIDE_W - 1;
	localparam int DIV_STEPS   = MAG_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	// Leap indicator value that marks an unsynchronised server.
	localparam logic [1:0] LEAP_ALARM = 2'b11;

	// Seconds between the NTP era origin and the Unix epoch, in 32.32 form.
	localparam logic [31:0] EPOCH_SECS = 32'h83aa7e80;
	localparam logic signed [WIDE_W-1:0] EPOCH_OFS = {3'b000, EPOCH_SECS, 32'h0};

	// Request kinds.
	localparam logic REQ_RESPONSE = 1'b0;
	localparam logic REQ_FINISH   = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK          = 2'd0,
		STATUS_NO_USABLE   = 2'd1,
		STATUS_NO_RESPONSE = 2'd2
	} noss_status_t;

	typedef struct packed {
		logic        req_type;
		logic [3:0]  server_index;
		logic [7:0]  stratum;
		logic [7:0]  header_flags;
		logic [31:0] root_delay;
		logic [31:0] root_dispersion;
		logic [63:0] origin_time;
		logic [63:0] server_receive_time;
		logic [63:0] server_transmit_time;
		logic [63:0] local_receive_time;
	} noss_req_t;

	typedef struct packed {
		noss_status_t       status;
		logic [3:0]         chosen_server;
		logic signed [63:0] average_offset;
		logic [2:0]         samples_used;
	} noss_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RESP_DIFF,
		ST_RESP_WR,
		ST_WALK,
		ST_DECIDE,
		ST_MEAN_RD,
		ST_MEAN_ACC,
		ST_ABS,
		ST_DIV,
		ST_LOAD
	} noss_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic resp_diff;
		logic resp_write;
		logic walk_start;
		logic walk_step;
		logic mean_start;
		logic mean_acc;
		logic div_init;
		logic div_step;
		logic load_out;
	} noss_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic req_is_finish;
		logic scan_zero;
		logic walk_last;
		logic any_resp;
		logic found;
		logic mean_last;
		logic div_last;
		logic out_free;
	} noss_sts_t;

endpackage

/* design/noss_if.sv */
// ----------------------------------------------------------------------------
// noss_req_if / noss_rsp_if
// Valid/ready channels carrying one request word and one result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface noss_req_if;
	logic                valid;
	logic                ready;
	noss_pkg::noss_req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface noss_rsp_if;
	logic                valid;
	logic                ready;
	noss_pkg::noss_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* design/noss_ctrl.sv */
// ----------------------------------------------------------------------------
// noss_ctrl
// Sequencer: response update, server walk, sample averaging and result load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module noss_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output noss_pkg::noss_cmd_t cmd,
	input  noss_pkg::noss_sts_t sts
);
	import noss_pkg::*;

	noss_state_t state_q;
	noss_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and command decode.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					if (sts.req_is_finish) begin
						cmd.walk_start = 1'b1;
						state_d = sts.scan_zero ? ST_LOAD : ST_WALK;
					end else begin
						state_d = ST_RESP_DIFF;
					end
				end
			end
			ST_RESP_DIFF: begin
				cmd.resp_diff = 1'b1;
				state_d = ST_RESP_WR;
			end
			ST_RESP_WR: begin
				cmd.resp_write = 1'b1;
				state_d = ST_IDLE;
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (sts.walk_last) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (sts.any_resp && sts.found) begin
					cmd.mean_start = 1'b1;
					state_d = ST_MEAN_RD;
				end else begin
					state_d = ST_LOAD;
				end
			end
			ST_MEAN_RD: begin
				state_d = ST_MEAN_ACC;
			end
			ST_MEAN_ACC: begin
				cmd.mean_acc = 1'b1;
				state_d = sts.mean_last ? ST_ABS : ST_MEAN_RD;
			end
			ST_ABS: begin
				cmd.div_init = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* design/noss_dp.sv */
// ----------------------------------------------------------------------------
// noss_dp
// Offset arithmetic, per-server store, selection registers, serial divider
// and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ntp_offset_server_select_assert.svh"

module noss_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  noss_pkg::noss_req_t            req_data,
	input  logic                           cfg_we,
	input  logic [noss_pkg::CFG_W-1:0]     cfg_wdata,
	input  noss_pkg::noss_cmd_t            cmd,
	output noss_pkg::noss_sts_t            sts,
	noss_rsp_if.source                     rsp
);
	import noss_pkg::*;

	// Captured request word and server count register.
	noss_req_t             req_q;
	logic [CFG_W-1:0]      server_count_q;
	logic [CFG_W-1:0]      scan_cnt;

	// Per-server metadata, cleared at reset and after every finish.
	logic [CNT_W-1:0]      sample_count_q [MAX_SERVERS];
	logic [7:0]            stratum_q      [MAX_SERVERS];
	logic [1:0]            leap_q         [MAX_SERVERS];
	logic [31:0]           delay_q        [MAX_SERVERS];
	logic [31:0]           disp_q         [MAX_SERVERS];

	// Offset sample memory.
	logic [TS_W-1:0]       mem_q [MEM_DEPTH];
	logic [TS_W-1:0]       mem_rdata_q;

	// Offset pipeline.
	logic signed [TS_W:0]  diff_tx_s1;
	logic signed [TS_W:0]  diff_rx_s1;
	logic signed [2:0]     corr_s1;
	logic signed [WIDE_W-1:0] corr_val;
	logic signed [WIDE_W-1:0] off_sum;
	logic [TS_W-1:0]       off_sat;
	logic [1:0]            nz_add;
	logic [1:0]            nz_sub;

	// Read index for the count store and response bookkeeping.
	logic [SRV_W-1:0]      rd_idx;
	logic [CNT_W-1:0]      cnt_rd;
	logic                  store_full;

	// Walk and selection.
	logic [SRV_W-1:0]      walk_i_q;
	logic                  any_q;
	logic                  found_q;
	logic [SRV_W-1:0]      best_q;
	logic [7:0]            best_strat_q;
	logic [31:0]           best_delay_q;
	logic [31:0]           best_disp_q;
	logic [CNT_W-1:0]      best_cnt_q;
	logic                  ent_usable;
	logic                  ent_better;
	logic                  ent_take;

	// Averaging and division.
	logic [CNT_W-1:0]      mean_j_q;
	logic signed [WIDE_W-1:0] acc_q;
	logic [WIDE_W-1:0]     acc_abs;
	logic                  neg_q;
	logic [MAG_W-1:0]      mag_q;
	logic [CNT_W-1:0]      rem_q;
	logic [CNT_W:0]        rem_try;
	logic                  rem_ge;
	logic [DIV_CNT_W-1:0]  div_cnt_q;

	// Result register.
	logic                  out_valid_q;
	noss_rsp_t             out_q;
	noss_rsp_t             out_d;
	logic [TS_W-1:0]       quot;

	function automatic logic local_nz(input logic [TS_W-1:0] t);
		return t != '0;
	endfunction

	// Request capture and configuration.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_count_q <= CFG_RESET;
		end else if (cfg_we) begin
			server_count_q <= cfg_wdata;
		end
	end

	assign scan_cnt = (server_count_q > CFG_W'(MAX_SERVERS)) ? CFG_W'(MAX_SERVERS)
		: server_count_q;

	// Offset stage one: two 65-bit differences and the epoch correction count.
	// A zero timestamp skips its epoch shift, so the shifts may not cancel.
	assign nz_add = 2'(local_nz(req_q.local_receive_time)) + 2'(local_nz(req_q.origin_time));
	assign nz_sub = 2'(local_nz(req_q.server_transmit_time))
		+ 2'(local_nz(req_q.server_receive_time));

	always_ff @(posedge clk) begin
		if (cmd.resp_diff) begin
			diff_tx_s1 <= $signed({1'b0, req_q.server_transmit_time})
				- $signed({1'b0, req_q.local_receive_time});
			diff_rx_s1 <= $signed({1'b0, req_q.server_receive_time})
				- $signed({1'b0, req_q.origin_time});
			corr_s1    <= $signed({1'b0, nz_add}) - $signed({1'b0, nz_sub});
		end
	end

	// Offset stage two: exact sum, halve with floor, saturate to 64 bits.
	always_comb begin
		case (corr_s1)
			-3'sd2:  corr_val = -(EPOCH_OFS <<< 1);
			-3'sd1:  corr_val = -EPOCH_OFS;
			3'sd1:   corr_val = EPOCH_OFS;
			3'sd2:   corr_val = EPOCH_OFS <<< 1;
			default: corr_val = '0;
		endcase
	end

	assign off_sum = WIDE_W'(diff_tx_s1) + WIDE_W'(diff_rx_s1) + corr_val;

	always_comb begin
		if ((off_sum[WIDE_W-1] == off_sum[TS_W+1]) && (off_sum[TS_W+1] == off_sum[TS_W])) begin
			off_sat = off_sum[TS_W:1];
		end else if (off_sum[WIDE_W-1]) begin
			off_sat = {1'b1, {(TS_W-1){1'b0}}};
		end else begin
			off_sat = {1'b0, {(TS_W-1){1'b1}}};
		end
	end

	// One index for the count read and the metadata write: the walk pointer or the request's server.
	assign rd_idx     = cmd.walk_step ? walk_i_q : req_q.server_index[SRV_W-1:0];
	assign cnt_rd     = sample_count_q[rd_idx];
	assign store_full = cnt_rd >= CNT_W'(SAMPLES);

	// Per-server metadata: append on a response unless the store is full, clear on result load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SERVERS; i++) begin
				sample_count_q[i] <= '0;
				stratum_q[i]      <= '0;
				leap_q[i]         <= '0;
				delay_q[i]        <= '0;
				disp_q[i]         <= '0;
			end
		end else if (cmd.load_out) begin
			for (int i = 0; i < MAX_SERVERS; i++) begin
				sample_count_q[i] <= '0;
				stratum_q[i]      <= '0;
				leap_q[i]         <= '0;
				delay_q[i]        <= '0;
				disp_q[i]         <= '0;
			end
		end else if (cmd.resp_write && !store_full) begin
			sample_count_q[rd_idx] <= cnt_rd + 1'b1;
			stratum_q[rd_idx]      <= req_q.stratum;
			leap_q[rd_idx]         <= req_q.header_flags[7:6];
			delay_q[rd_idx]        <= req_q.root_delay;
			disp_q[rd_idx]         <= req_q.root_dispersion;
		end
	end

	// Sample memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.resp_write && !store_full) begin
			mem_q[{rd_idx, cnt_rd[SMP_W-1:0]}] <= off_sat;
		end
		mem_rdata_q <= mem_q[{best_q, mean_j_q[SMP_W-1:0]}];
	end

	// Selection test for the server under the walk pointer.
	assign ent_usable = (stratum_q[walk_i_q] != '0) && (leap_q[walk_i_q] != LEAP_ALARM);
	assign ent_better = (stratum_q[walk_i_q] <= best_strat_q)
		&& (disp_q[walk_i_q] <= best_disp_q)
		&& (delay_q[walk_i_q] < best_delay_q);
	assign ent_take   = ent_usable && (!found_q || ent_better);

	// Walk control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_i_q <= '0;
			any_q    <= 1'b0;
			found_q  <= 1'b0;
		end else if (cmd.walk_start) begin
			walk_i_q <= '0;
			any_q    <= 1'b0;
			found_q  <= 1'b0;
		end else if (cmd.walk_step) begin
			walk_i_q <= walk_i_q + 1'b1;
			any_q    <= any_q || (cnt_rd != '0);
			found_q  <= found_q || ent_take;
		end
	end

	// Best candidate so far.
	always_ff @(posedge clk) begin
		if (cmd.walk_step && ent_take) begin
			best_q       <= walk_i_q;
			best_strat_q <= stratum_q[walk_i_q];
			best_delay_q <= delay_q[walk_i_q];
			best_disp_q  <= disp_q[walk_i_q];
			best_cnt_q   <= cnt_rd;
		end
	end

	// Sample sum for the chosen server.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_j_q <= '0;
		end else if (cmd.mean_start) begin
			mean_j_q <= '0;
		end else if (cmd.mean_acc) begin
			mean_j_q <= mean_j_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mean_start) begin
			acc_q <= '0;
		end else if (cmd.mean_acc) begin
			acc_q <= acc_q + WIDE_W'($signed(mem_rdata_q));
		end
	end

	// Serial restoring divider on the magnitude, one quotient bit a cycle.
	// The dividend shifts out at the top while quotient bits enter below.
	assign acc_abs = acc_q[WIDE_W-1] ? (WIDE_W'(0) - acc_q) : acc_q;
	assign rem_try = {rem_q, mag_q[MAG_W-1]};
	assign rem_ge  = rem_try >= {1'b0, best_cnt_q};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			neg_q <= acc_q[WIDE_W-1];
			mag_q <= acc_abs[MAG_W-1:0];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			mag_q <= {mag_q[MAG_W-2:0], rem_ge};
			rem_q <= rem_ge ? CNT_W'(rem_try - {1'b0, best_cnt_q}) : rem_try[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_init) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	// Result word.
	assign quot = mag_q[TS_W-1:0];

	always_comb begin
		out_d = '0;
		if (!any_q) begin
			out_d.status = STATUS_NO_RESPONSE;
		end else if (!found_q) begin
			out_d.status = STATUS_NO_USABLE;
		end else begin
			out_d.status         = STATUS_OK;
			out_d.chosen_server  = 4'(best_q);
			out_d.average_offset = neg_q ? (TS_W'(0) - quot) : quot;
			out_d.samples_used   = 3'(best_cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= out_d;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// Status back to the controller.
	always_comb begin
		sts.req_is_finish = req_data.req_type == REQ_FINISH;
		sts.scan_zero     = scan_cnt == '0;
		sts.walk_last     = (CFG_W'(walk_i_q) + 1'b1) == scan_cnt;
		sts.any_resp      = any_q;
		sts.found         = found_q;
		sts.mean_last     = CNT_W'(mean_j_q + 1'b1) == best_cnt_q;
		sts.div_last      = div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1);
		sts.out_free      = !out_valid_q || rsp.ready;
	end

	// Checks.
	`NOSS_ASSERT_IMP(a_load_when_free, cmd.load_out, !out_valid_q || rsp.ready, "result register overwritten")
	`NOSS_ASSERT_IMP(a_best_has_samples, found_q, (best_strat_q != '0) && (best_cnt_q != '0), "selected server without samples")
	`NOSS_ASSERT_NXT(a_rem_below_divisor, cmd.div_step, rem_q < best_cnt_q, "divider remainder out of range")
	`NOSS_ASSERT_IMP(a_ok_counts_samples, out_valid_q && (out_q.status == STATUS_OK), out_q.samples_used != '0, "ok result with no samples")

endmodule

/* design/ntp_offset_server_select.sv */
// ----------------------------------------------------------------------------
// ntp_offset_server_select: NTP clock offset store and peer selection.
// A response word is accepted, differenced, then summed and written to the store.
// A finish walks the scanned servers and averages the chosen one's samples; with none
// scanned or usable it loads the result directly. Reset clears the store; server count 16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ntp_offset_server_select (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [noss_pkg::CFG_W-1:0] cfg_wdata,
	noss_req_if.sink                   req,
	noss_rsp_if.source                 rsp
);
	import noss_pkg::*;

	noss_cmd_t cmd;
	noss_sts_t sts;
	logic      ctrl_ready;

	// Sequencer.
	noss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ctrl_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	assign req.ready = ctrl_ready;

	// Arithmetic, store and result register.
	noss_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req.data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

/* test/tb_ntp_offset_server_select.sv */
// ----------------------------------------------------------------------------
// tb_ntp_offset_server_select
// Self-checking bench for the NTP offset store and peer selection block.
// Request words go in through a bursty valid/ready driver. A behavioural
// predictor follows every accepted word and queues the selection that each
// finish word should produce. A monitor, stalling on its own pattern,
// compares every result field by field. The server count register is
// rewritten between phases, so the phases cover several scan ranges.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ntp_offset_server_select;
	import noss_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_WORDS = 140;
	localparam int PHASES      = 8;
	localparam int DRAIN_WAIT  = 8;
	localparam int FINAL_WAIT  = 120;
	localparam logic signed [67:0] OFFSET_MAX = 68'sh0_7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [67:0] OFFSET_MIN = -OFFSET_MAX - 68'sd1;
	localparam logic [63:0] STAMP_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	// Receiver stall patterns.
	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_COIN,
		SINK_EVERY4,
		SINK_SPARSE
	} sink_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_W-1:0]     cfg_wdata;

	noss_req_if req_ch ();
	noss_rsp_if rsp_ch ();

	ntp_offset_server_select dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	always #5 clk = ~clk;

	// Predictor state: a copy of what the block should hold per server.
	logic [CNT_W-1:0]   held_count [MAX_SERVERS];
	logic [7:0]         held_stratum [MAX_SERVERS];
	logic [1:0]         held_leap [MAX_SERVERS];
	logic [31:0]        held_delay [MAX_SERVERS];
	logic [31:0]        held_disp [MAX_SERVERS];
	logic signed [63:0] held_offset [MAX_SERVERS][SAMPLES];
	logic [CFG_W-1:0]   server_count_cfg;

	noss_req_t pending_words [$];
	noss_rsp_t expected_selections [$];

	int unsigned errors;
	int unsigned words_sent;
	int unsigned finishes_sent;
	int unsigned selections_checked;
	int unsigned status_seen [3];
	int unsigned cfg_writes;
	int unsigned cycles;

	int          burst_left;
	int          gap_left;
	int          stall_left;
	sink_mode_t  stall_mode;

	function automatic void flag_error(string msg);
		errors++;
		if (errors <= 10) begin
			$display("MISMATCH at %0t: %s", $realtime, msg);
		end
	endfunction

	function automatic void clear_held();
		for (int s = 0; s < MAX_SERVERS; s++) begin
			held_count[s]   = '0;
			held_stratum[s] = '0;
			held_leap[s]    = '0;
			held_delay[s]   = '0;
			held_disp[s]    = '0;
			for (int k = 0; k < SAMPLES; k++) begin
				held_offset[s][k] = '0;
			end
		end
	endfunction

	// A zero timestamp stands for the Unix epoch itself.
	function automatic logic signed [67:0] to_unix(input logic [63:0] stamp);
		if (stamp == 64'd0) begin
			return 68'sd0;
		end
		return $signed({4'b0000, stamp}) - $signed({4'b0000, EPOCH_SECS, 32'h0});
	endfunction

	// Exact offset, floored to 32.32 units and clipped to signed 64 bits.
	function automatic logic signed [63:0] clock_offset(input logic [63:0] ot, rt, tt, lt);
		logic signed [67:0] sum;
		sum = (to_unix(tt) - to_unix(lt)) + (to_unix(rt) - to_unix(ot));
		sum = sum >>> 1;
		if (sum > OFFSET_MAX) begin
			return OFFSET_MAX[63:0];
		end
		if (sum < OFFSET_MIN) begin
			return OFFSET_MIN[63:0];
		end
		return sum[63:0];
	endfunction

	// Mean of a server's offsets, truncated toward zero.
	function automatic logic signed [63:0] truncated_mean(input int unsigned srv,
			input int unsigned n);
		logic signed [67:0] acc;
		logic signed [67:0] divisor;
		logic signed [67:0] quot;
		acc = '0;
		divisor = n;
		for (int k = 0; k < n; k++) begin
			acc = acc + {{4{held_offset[srv][k][63]}}, held_offset[srv][k]};
		end
		quot = acc / divisor;
		return quot[63:0];
	endfunction

	// A response lands in its server's store unless that store is full.
	function automatic void accumulate_response(input noss_req_t w);
		int unsigned idx;
		idx = w.server_index;
		if (held_count[idx] >= SAMPLES) begin
			return;
		end
		held_offset[idx][held_count[idx]] = clock_offset(w.origin_time,
			w.server_receive_time, w.server_transmit_time, w.local_receive_time);
		held_count[idx]   = held_count[idx] + 1'b1;
		held_stratum[idx] = w.stratum;
		held_leap[idx]    = w.header_flags[7:6];
		held_delay[idx]   = w.root_delay;
		held_disp[idx]    = w.root_dispersion;
	endfunction

	// Walk the scanned servers, pick the best one and clear the store.
	function automatic noss_rsp_t select_peer();
		noss_rsp_t   r;
		int unsigned scan;
		int unsigned best;
		bit          any;
		bit          found;
		scan  = (server_count_cfg > MAX_SERVERS) ? MAX_SERVERS : server_count_cfg;
		best  = 0;
		any   = 1'b0;
		found = 1'b0;
		for (int unsigned i = 0; i < scan; i++) begin
			if (held_count[i] != 0) begin
				any = 1'b1;
			end
			if (held_stratum[i] == 8'd0 || held_leap[i] == LEAP_ALARM) begin
				continue;
			end
			if (!found) begin
				found = 1'b1;
				best  = i;
			end else if (held_stratum[i] <= held_stratum[best] &&
					held_disp[i] <= held_disp[best] &&
					held_delay[i] < held_delay[best]) begin
				best = i;
			end
		end
		r = '0;
		if (!any) begin
			r.status = STATUS_NO_RESPONSE;
		end else if (!found) begin
			r.status = STATUS_NO_USABLE;
		end else begin
			r.status         = STATUS_OK;
			r.chosen_server  = 4'(best);
			r.average_offset = truncated_mean(best, held_count[best]);
			r.samples_used   = held_count[best];
		end
		clear_held();
		return r;
	endfunction

	function automatic noss_req_t finish_word();
		noss_req_t w;
		w = '0;
		w.req_type = REQ_FINISH;
		return w;
	endfunction

	function automatic noss_req_t response_word(input int unsigned srv,
			input logic [7:0] stratum, input logic [7:0] flags,
			input logic [31:0] delay, input logic [31:0] disp,
			input logic [63:0] ot, rt, tt, lt);
		noss_req_t w;
		w.req_type             = REQ_RESPONSE;
		w.server_index         = 4'(srv);
		w.stratum              = stratum;
		w.header_flags         = flags;
		w.root_delay           = delay;
		w.root_dispersion      = disp;
		w.origin_time          = ot;
		w.server_receive_time  = rt;
		w.server_transmit_time = tt;
		w.local_receive_time   = lt;
		return w;
	endfunction

	// Plausible exchange around a random instant, with an occasional odd stamp.
	function automatic noss_req_t random_response(input int unsigned srv);
		logic [63:0] base, trip, turn, skew;
		logic [63:0] ot, rt, tt, lt;
		logic [7:0]  stratum;
		logic [1:0]  leap;
		logic [31:0] delay, disp;
		base = {$urandom_range(32'hE000_0000, 32'hEFFF_FFFF), $urandom};
		trip = 64'($urandom_range(0, 32'h3FFF_FFFF));
		turn = 64'($urandom_range(0, 32'h00FF_FFFF));
		skew = {32'($urandom_range(0, 15)), $urandom} - 64'h0000_0008_0000_0000;
		ot = base;
		rt = base + trip + skew;
		tt = rt + turn;
		lt = tt + trip - skew;
		case ($urandom_range(0, 19))
			0: ot = '0;
			1: lt = '0;
			2: rt = '0;
			3: tt = '0;
			4: tt = STAMP_ONES;
			5: rt = {$urandom, $urandom};
			6: begin
				ot = {$urandom, $urandom};
				rt = {$urandom, $urandom};
				tt = {$urandom, $urandom};
				lt = {$urandom, $urandom};
			end
			default: ;
		endcase
		if ($urandom_range(0, 15) == 0) begin
			stratum = 8'd0;
		end else if ($urandom_range(0, 7) == 0) begin
			stratum = 8'($urandom);
		end else begin
			stratum = 8'($urandom_range(1, 4));
		end
		leap  = ($urandom_range(0, 9) == 0) ? LEAP_ALARM : 2'($urandom_range(0, 2));
		delay = $urandom_range(0, 1) ? 32'($urandom_range(0, 3)) : $urandom;
		disp  = $urandom_range(0, 1) ? 32'($urandom_range(0, 3)) : $urandom;
		return response_word(srv, stratum, {leap, 6'($urandom)}, delay, disp, ot, rt, tt, lt);
	endfunction

	// Random bits over the whole word, request kind included.
	function automatic noss_req_t noise_word();
		logic [351:0] bits;
		for (int i = 0; i < 11; i++) begin
			bits[i*32 +: 32] = $urandom;
		end
		return noss_req_t'(bits[$bits(noss_req_t)-1:0]);
	endfunction

	task automatic load_directed();
		noss_req_t w;
		// Finish with an empty store, then with only an unusable server.
		pending_words.push_back(finish_word());
		pending_words.push_back(response_word(0, 8'd0, 8'h00, 32'd5, 32'd5,
			64'd0, 64'd0, 64'd0, 64'd0));
		pending_words.push_back(finish_word());
		// Alarmed leap indicator beside a server at the field extremes.
		pending_words.push_back(response_word(3, 8'd1, 8'hC0, 32'd1, 32'd1,
			64'd1, 64'd1, 64'd1, 64'd1));
		pending_words.push_back(response_word(5, 8'hFF, 8'h3F, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 64'd0, 64'd0, 64'd0, 64'd0));
		pending_words.push_back(finish_word());
		// Saturation both ways, and all stamps at their maximum.
		pending_words.push_back(response_word(1, 8'd3, 8'h40, 32'd100, 32'd100,
			64'd1, STAMP_ONES, STAMP_ONES, 64'd1));
		pending_words.push_back(response_word(1, 8'd3, 8'h80, 32'd100, 32'd100,
			64'd0, 64'd1, 64'd1, 64'd0));
		pending_words.push_back(response_word(1, 8'd3, 8'h00, 32'd100, 32'd100,
			STAMP_ONES, STAMP_ONES, STAMP_ONES, STAMP_ONES));
		// Five responses to one server: the fifth meets a full store.
		for (int k = 0; k < 5; k++) begin
			w = random_response(2);
			w.stratum         = (k == 4) ? 8'd9 : 8'd2;
			w.header_flags    = 8'h1B;
			w.root_delay      = 32'd80;
			w.root_dispersion = 32'd50;
			pending_words.push_back(w);
		end
		// Tie-breaking: equal stratum and dispersion with lower delay wins,
		// equal delay does not, and an alarmed server never does.
		w = random_response(4);
		pending_words.push_back(response_word(4, 8'd2, 8'h00, 32'd40, 32'd50,
			w.origin_time, w.server_receive_time, w.server_transmit_time,
			w.local_receive_time));
		pending_words.push_back(response_word(6, 8'd1, 8'h00, 32'd40, 32'd10,
			w.origin_time, w.server_receive_time, w.server_transmit_time,
			w.local_receive_time));
		pending_words.push_back(response_word(7, 8'd1, 8'hFF, 32'd0, 32'd0,
			w.origin_time, w.server_receive_time, w.server_transmit_time,
			w.local_receive_time));
		pending_words.push_back(response_word(15, 8'd2, 8'h00, 32'd1, 32'd51,
			w.origin_time, w.server_receive_time, w.server_transmit_time,
			w.local_receive_time));
		pending_words.push_back(finish_word());
		// The highest server index on its own.
		pending_words.push_back(random_response(15));
		pending_words.push_back(finish_word());
	endtask

	// Sessions of responses closed by a finish, with some noise mixed in.
	task automatic load_random(input int unsigned target);
		int unsigned added;
		int unsigned reach;
		int unsigned n;
		int unsigned srv;
		added = 0;
		reach = (server_count_cfg == 0 || server_count_cfg > MAX_SERVERS) ?
			MAX_SERVERS : server_count_cfg;
		while (added < target) begin
			n = ($urandom_range(0, 9) == 0) ? 0 :
				$urandom_range(1, (reach * SAMPLES + 1 < 12) ? reach * SAMPLES + 1 : 12);
			for (int unsigned k = 0; k < n; k++) begin
				srv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_SERVERS - 1) :
					$urandom_range(0, reach - 1);
				if ($urandom_range(0, 11) == 0) begin
					pending_words.push_back(noise_word());
				end else begin
					pending_words.push_back(random_response(srv));
				end
			end
			pending_words.push_back(finish_word());
			added += n + 1;
		end
	endtask

	// Wait until every word has gone in and every result has come out.
	// Sampled on the falling edge, once the driver's updates have settled.
	task automatic drain();
		while (pending_words.size() != 0 || req_ch.valid === 1'b1 ||
				expected_selections.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_server_count(input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		server_count_cfg = value;
		cfg_writes++;
	endtask

	// Driver: bursts of words with random gaps, holding each word until taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data  <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				words_sent++;
				if (req_ch.data.req_type == REQ_FINISH) begin
					finishes_sent++;
					expected_selections.push_back(select_peer());
				end else begin
					accumulate_response(req_ch.data);
				end
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					req_ch.data  <= pending_words.pop_front();
					req_ch.valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result and changes its stall pattern now and then.
	always @(posedge clk or negedge arst_n) begin
		noss_rsp_t want;
		noss_rsp_t got;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
			stall_mode = SINK_OPEN;
		end else begin
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
				got = rsp_ch.data;
				if (expected_selections.size() == 0) begin
					flag_error($sformatf("result with nothing pending: status %0d server %0d",
						got.status, got.chosen_server));
				end else begin
					want = expected_selections.pop_front();
					selections_checked++;
					if (want.status <= STATUS_NO_RESPONSE) begin
						status_seen[want.status]++;
					end
					if (got.status !== want.status) begin
						flag_error($sformatf("status: expected %0d, got %0d",
							want.status, got.status));
					end
					if (got.chosen_server !== want.chosen_server) begin
						flag_error($sformatf("chosen_server: expected %0d, got %0d",
							want.chosen_server, got.chosen_server));
					end
					if (got.average_offset !== want.average_offset) begin
						flag_error($sformatf("average_offset: expected %h, got %h",
							want.average_offset, got.average_offset));
					end
					if (got.samples_used !== want.samples_used) begin
						flag_error($sformatf("samples_used: expected %0d, got %0d",
							want.samples_used, got.samples_used));
					end
				end
			end
			if (stall_left == 0) begin
				stall_mode = sink_mode_t'($urandom_range(0, 3));
				stall_left = $urandom_range(20, 120);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				SINK_OPEN:   rsp_ch.ready <= 1'b1;
				SINK_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
				SINK_EVERY4: rsp_ch.ready <= (stall_left % 4 == 0);
				default:     rsp_ch.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycles, expected_selections.size());
			$display("ntp_offset_server_select test failed");
			$finish;
		end
	end

	// Stimulus sequence: reset, directed words, then random phases.
	initial begin
		logic [CFG_W-1:0] phase_count [PHASES];
		logic [CFG_W-1:0] value;
		phase_count = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd2, 5'd17, 5'd3, 5'd16};
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		cfg_writes = 0;
		server_count_cfg = CFG_RESET;
		clear_held();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		load_directed();
		drain();

		for (int p = 0; p < PHASES; p++) begin
			value = (p == 6) ? CFG_W'($urandom_range(3, 15)) : phase_count[p];
			write_server_count(value);
			load_random(PHASE_WORDS);
			drain();
		end

		repeat (FINAL_WAIT) @(posedge clk);
		if (expected_selections.size() != 0) begin
			flag_error($sformatf("%0d results never arrived", expected_selections.size()));
		end

		$display("Sent %0d request words (%0d finish) across %0d server-count settings.",
			words_sent, finishes_sent, cfg_writes + 1);
		$display("Checked %0d selections: %0d ok, %0d no usable server, %0d no response.",
			selections_checked, status_seen[0], status_seen[1], status_seen[2]);
		if (errors == 0) begin
			$display("ntp_offset_server_select test passed");
		end else begin
			$display("%0d mismatches in total.", errors);
			$display("ntp_offset_server_select test failed");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+design
design/noss_pkg.sv
design/noss_if.sv
design/noss_ctrl.sv
design/noss_dp.sv
design/ntp_offset_server_select.sv
test/tb_ntp_offset_server_select.sv
